>>> rtl/core/sbdr_pkg.sv
// Package: phase and status codes and header constants of the bank dump receiver.
package sbdr_pkg;

  typedef enum logic [3:0] {
    PH_HUNT      = 4'd0,
    PH_MAKER     = 4'd1,
    PH_CHAN      = 4'd2,
    PH_FORMAT    = 4'd3,
    PH_COUNT_HI  = 4'd4,
    PH_COUNT_LO  = 4'd5,
    PH_DATA      = 4'd6,
    PH_SUM       = 4'd7,
    PH_END       = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    ST_REALTIME   = 4'd0,
    ST_HUNT       = 4'd1,
    ST_HEADER     = 4'd2,
    ST_PAYLOAD    = 4'd3,
    ST_CKSUM      = 4'd4,
    ST_DONE       = 4'd5,
    ST_ERR_DATA   = 4'd6,
    ST_ERR_STATUS = 4'd7,
    ST_ERR_COUNT  = 4'd8,
    ST_ERR_CKSUM  = 4'd9,
    ST_ERR_EOX    = 4'd10,
    ST_ERR_EOF    = 4'd11,
    ST_HALTED     = 4'd12
  } status_t;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;
  localparam logic [7:0] REALTIME_LO = 8'hF8;
  localparam logic [6:0] MAKER_ID    = 7'h43;
  localparam logic [6:0] FORMAT_ID   = 7'h09;

  // One result word as it sits in the output stages.
  typedef struct packed {
    status_t    status;
    logic [6:0] payload_byte;
    logic [11:0] payload_index;
  } result_t;

endpackage

>>> rtl/core/sbdr_if.sv
// Interfaces: input byte, result and configuration channels of the bank dump receiver.
interface sbdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_input;

  modport source (output valid, output rx_byte, output end_of_input, input ready);
  modport sink (input valid, input rx_byte, input end_of_input, output ready);
endinterface

interface sbdr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [6:0]  payload_byte;
  logic [11:0] payload_index;

  modport source (output valid, output status, output payload_byte,
                  output payload_index, input ready);
  modport sink (input valid, input status, input payload_byte,
                input payload_index, output ready);
endinterface

interface sbdr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] device_channel;

  modport source (output valid, output device_channel, input ready);
  modport sink (input valid, input device_channel, output ready);
endinterface

>>> rtl/core/sysex_bank_dump_receiver_core.sv
// Top level: bank bulk dump frame parser with 7-bit checksum and payload streaming.
//
// Usage: feed received MIDI bytes on the rx channel, one word per byte; raise
// end_of_input on a word to report that the source ended. Every accepted rx
// word gives exactly one result word on the result channel: a status code and,
// for payload bytes, the byte and its index within the dump. The cfg channel
// writes the expected device channel; it is always ready and should be used
// only while the block is idle.
// A result is registered from its accepted rx word. Throughput: one word per
// cycle while rx ready is high; the per-byte parser is a single pass of
// compare and 7-bit add logic between the rx handshake and the result register.
// Stalls: a result register plus a one-word skid stage sit behind the parser,
// so a new word is taken while one result waits; rx ready drops only when the
// skid stage is full, and reads back high the cycle after the sink takes one.
// Reset (rst, synchronous): hunt for F0, clear count, sum and halt flag,
// device channel 0, both output stages empty. After done or any error the
// block answers "halted" to every word until reset.
module sysex_bank_dump_receiver_core
  import sbdr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  sbdr_in_if.sink           rx,
  sbdr_out_if.source        result,
  sbdr_cfg_if.sink          cfg
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [6:0] COUNT_HI = 7'((PAYLOAD_BYTES >> 7) & 127);
  localparam logic [6:0] COUNT_LO = 7'(PAYLOAD_BYTES & 127);

  // Parser state
  phase_t             phase;
  logic [CNT_W-1:0]   payload_count;
  logic [6:0]         running_sum;
  logic               halted_flag;
  logic [3:0]         device_channel;

  phase_t             phase_next;
  logic [CNT_W-1:0]   payload_count_next;
  logic [6:0]         running_sum_next;
  logic               halted_flag_next;
  result_t            res_next;

  // Output stages
  logic    out_valid;
  result_t out_word;
  logic    skid_valid;
  result_t skid_word;

  logic             accept;
  logic             taken;
  logic [CNT_W-1:0] cnt_inc;
  logic [13:0]      cnt_ext;
  logic [6:0]       data7;
  logic [6:0]       header_want;

  assign rx.ready  = !skid_valid;
  assign accept    = rx.valid && rx.ready;
  assign taken     = out_valid && result.ready;
  assign cfg.ready = 1'b1;

  assign cnt_inc = payload_count + CNT_W'(1);
  assign cnt_ext = 14'(payload_count);
  assign data7   = rx.rx_byte[6:0];

  always_comb begin
    unique case (phase)
      PH_MAKER: header_want = MAKER_ID;
      PH_CHAN:  header_want = {3'b000, device_channel};
      default:  header_want = FORMAT_ID;
    endcase
  end

  // Per-byte transition: one status word per input word
  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    halted_flag_next   = halted_flag;
    res_next.status        = ST_HUNT;
    res_next.payload_byte  = 7'd0;
    res_next.payload_index = 12'd0;

    if (halted_flag) begin
      res_next.status = ST_HALTED;
    end else if (rx.end_of_input) begin
      res_next.status  = ST_ERR_EOF;
      halted_flag_next = 1'b1;
    end else if (rx.rx_byte >= REALTIME_LO) begin
      // real-time bytes pass through the frame untouched
      res_next.status = ST_REALTIME;
    end else if (phase == PH_HUNT) begin
      payload_count_next = '0;
      running_sum_next   = 7'd0;
      if (rx.rx_byte == SYSEX_START) begin
        phase_next      = PH_MAKER;
        res_next.status = ST_HEADER;
      end else begin
        res_next.status = ST_HUNT;
      end
    end else if (phase == PH_END) begin
      halted_flag_next = 1'b1;
      if (!rx.rx_byte[7]) begin
        res_next.status = ST_ERR_STATUS;
      end else if (rx.rx_byte != SYSEX_END) begin
        res_next.status = ST_ERR_EOX;
      end else begin
        res_next.status = ST_DONE;
      end
    end else if (rx.rx_byte[7]) begin
      res_next.status  = ST_ERR_DATA;
      halted_flag_next = 1'b1;
    end else if (phase == PH_MAKER || phase == PH_CHAN || phase == PH_FORMAT) begin
      if (data7 == header_want) begin
        phase_next      = phase_t'(phase + 4'd1);
        res_next.status = ST_HEADER;
      end else begin
        // resync: back to hunting; the byte has bit 7 clear, so it is not F0
        phase_next         = PH_HUNT;
        payload_count_next = '0;
        running_sum_next   = 7'd0;
        res_next.status    = ST_HUNT;
      end
    end else if (phase == PH_COUNT_HI || phase == PH_COUNT_LO) begin
      if (data7 == ((phase == PH_COUNT_HI) ? COUNT_HI : COUNT_LO)) begin
        phase_next      = phase_t'(phase + 4'd1);
        res_next.status = ST_HEADER;
      end else begin
        res_next.status  = ST_ERR_COUNT;
        halted_flag_next = 1'b1;
      end
    end else if (phase == PH_DATA) begin
      running_sum_next       = running_sum + data7;
      res_next.payload_byte  = data7;
      res_next.payload_index = cnt_ext[11:0];
      payload_count_next     = cnt_inc;
      res_next.status        = ST_PAYLOAD;
      if (cnt_inc == CNT_W'(PAYLOAD_BYTES)) begin
        phase_next = PH_SUM;
      end
    end else begin
      // checksum byte: must equal minus the 7-bit sum
      if (data7 != 7'(7'd0 - running_sum)) begin
        res_next.status  = ST_ERR_CKSUM;
        halted_flag_next = 1'b1;
      end else begin
        phase_next      = PH_END;
        res_next.status = ST_CKSUM;
      end
    end
  end

  // Parser state: advance only on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      payload_count <= '0;
      running_sum   <= 7'd0;
      halted_flag   <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      halted_flag   <= halted_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_channel <= 4'd0;
    end else if (cfg.valid) begin
      device_channel <= cfg.device_channel;
    end
  end

  // Output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || taken) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || taken) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept) begin
        out_word <= res_next;
      end
    end else if (accept) begin
      skid_word <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_word.status;
  assign result.payload_byte  = out_word.payload_byte;
  assign result.payload_index = out_word.payload_index;

endmodule
